// ===== hw/rtl/cpt_pkg.sv =====
// Package for the Clarke/Park transform: mode codes, Q1.15 coefficients,
// the quarter-wave sine table and the round-and-saturate helper.
// No dependencies; used by clarke_park_transform.
`timescale 1ns / 1ps

package cpt_pkg;

	// Angle resolution: a full turn is 2^ANGLE_BITS counts.
	localparam int ANGLE_BITS = 12;
	localparam int QUARTER    = 1 << (ANGLE_BITS - 2);
	localparam int ROM_AW     = ANGLE_BITS - 1;   // addresses 0 .. QUARTER
	localparam int SINE_W     = 15;               // magnitudes up to 32767

	localparam int SAMPLE_W = 16;
	localparam int COEF_W   = 17;
	localparam int PROD_W   = 2 * COEF_W;
	localparam int SUM_W    = PROD_W + 1;

	// Transform selector carried in tuser.
	typedef enum logic [1:0] {
		MODE_CLARKE  = 2'd0,
		MODE_ICLARKE = 2'd1,
		MODE_PARK    = 2'd2,
		MODE_IPARK   = 2'd3
	} mode_t;

	// Rounded Q1.15 coefficients.
	localparam logic signed [COEF_W-1:0] C_TWO_THIRDS = 17'sd21845;
	localparam logic signed [COEF_W-1:0] C_NEG_THIRD  = -17'sd10923;
	localparam logic signed [COEF_W-1:0] C_SQRT3_3    = 17'sd18919;
	localparam logic signed [COEF_W-1:0] C_ONE        = 17'sd32768;
	localparam logic signed [COEF_W-1:0] C_NEG_HALF   = -17'sd16384;
	localparam logic signed [COEF_W-1:0] C_SQRT3_2    = 17'sd28378;

	localparam real PI_R = 3.14159265358979323846;
	// Angle step of one table entry, in radians.
	localparam real ROM_STEP = PI_R / (2.0 * QUARTER);

	typedef logic [SINE_W-1:0] sine_rom_t [QUARTER+1];

	// Quarter-wave table: round(32767 * sin(pi/2 * r / QUARTER)).
	function automatic sine_rom_t build_sine();
		sine_rom_t t;
		real       v;
		for (int r = 0; r <= QUARTER; r++) begin
			v    = 32767.0 * $sin(ROM_STEP * r);
			t[r] = SINE_W'($rtoi(v + 0.5));
		end
		return t;
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine();

	// One rounded and clipped output with its clip flag.
	typedef struct packed {
		logic                       sat;
		logic signed [SAMPLE_W-1:0] val;
	} sat_res_t;

	// Round a Q2.30 sum half up to Q1.15, then clip to the Q1.15 range.
	function automatic sat_res_t round_sat(input logic signed [SUM_W-1:0] acc);
		logic signed [SUM_W:0]   t;
		logic signed [SUM_W-15:0] q;
		sat_res_t                 res;
		t = {acc[SUM_W-1], acc} + (SUM_W+1)'(16384);
		q = t[SUM_W:15];
		if (q > (SUM_W-14)'(32767)) begin
			res.sat = 1'b1;
			res.val = 16'sh7FFF;
		end else if (q < -(SUM_W-14)'(32768)) begin
			res.sat = 1'b1;
			res.val = 16'sh8000;
		end else begin
			res.sat = 1'b0;
			res.val = q[SAMPLE_W-1:0];
		end
		return res;
	endfunction

endpackage

// ===== hw/rtl/clarke_park_transform.sv =====
// Clarke / inverse Clarke / Park / inverse Park transform, three-stage pipeline.
// Depends on cpt_pkg for mode codes, coefficients, sine table and rounding.
`timescale 1ns / 1ps

// One transaction in gives one transaction out: the result is offered from the
// stage 3 register and is held until the output side takes it. A new transaction
// can be taken every cycle unless a stalled output has filled all stages, since
// each stage moves whenever it is empty or the stage after it moves. Stage 1
// registers the sample set and reads sine and cosine from the quarter-wave
// ROM, stage 2 selects coefficients and forms four 17x17 products, stage 3
// adds, rounds half up to Q1.15 and clips. The saturated flag is set when any
// output of the transaction was clipped; out_c is zero outside inverse Clarke.
module clarke_park_transform (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // in_a[15:0], in_b[31:16], in_c[47:32], angle[59:48]
	input  logic [1:0]  s_axis_tuser,   // mode[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,   // out_a[15:0], out_b[31:16], out_c[47:32]
	output logic [0:0]  m_axis_tuser    // saturated[0]
);

	localparam int AW = cpt_pkg::ROM_AW;
	localparam int CW = cpt_pkg::COEF_W;
	localparam int PW = cpt_pkg::PROD_W;
	localparam int SW = cpt_pkg::SUM_W;

	// Pipeline advance: a stage moves when it is empty or the next one moves.
	logic v_s1, v_s2, v_s3;
	logic en1, en2, en3;

	assign en3           = !v_s3 || m_axis_tready;
	assign en2           = !v_s2 || en3;
	assign en1           = !v_s1 || en2;
	assign s_axis_tready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= s_axis_tvalid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	// Stage 1: unpack, quadrant fold of the angle, ROM addresses.
	logic signed [15:0]          in_a, in_b, in_c;
	logic [cpt_pkg::ANGLE_BITS-1:0] angle;
	logic [1:0]                  quad, cquad;
	logic [cpt_pkg::ANGLE_BITS-3:0] frac;
	logic [AW-1:0]               sin_addr, cos_addr;

	assign in_a  = s_axis_tdata[15:0];
	assign in_b  = s_axis_tdata[31:16];
	assign in_c  = s_axis_tdata[47:32];
	assign angle = s_axis_tdata[48 +: cpt_pkg::ANGLE_BITS];
	assign quad  = angle[cpt_pkg::ANGLE_BITS-1 -: 2];
	assign frac  = angle[cpt_pkg::ANGLE_BITS-3:0];
	// Cosine is the sine a quarter turn ahead: same fraction, next quadrant.
	assign cquad = quad + 2'd1;

	assign sin_addr = quad[0]  ? AW'(cpt_pkg::QUARTER) - AW'(frac) : AW'(frac);
	assign cos_addr = cquad[0] ? AW'(cpt_pkg::QUARTER) - AW'(frac) : AW'(frac);

	cpt_pkg::mode_t                 mode_s1;
	logic signed [15:0]             a_s1, b_s1;
	logic signed [16:0]             bpc_s1, bmc_s1;
	logic [cpt_pkg::SINE_W-1:0]     sin_mag_s1, cos_mag_s1;
	logic                           sin_neg_s1, cos_neg_s1;

	// Input register and registered ROM read, both held on a stall.
	always_ff @(posedge clk) begin
		if (en1) begin
			mode_s1    <= cpt_pkg::mode_t'(s_axis_tuser);
			a_s1       <= in_a;
			b_s1       <= in_b;
			bpc_s1     <= {in_b[15], in_b} + {in_c[15], in_c};
			bmc_s1     <= {in_b[15], in_b} - {in_c[15], in_c};
			sin_mag_s1 <= cpt_pkg::SINE_ROM[sin_addr];
			cos_mag_s1 <= cpt_pkg::SINE_ROM[cos_addr];
			sin_neg_s1 <= quad[1];
			cos_neg_s1 <= cquad[1];
		end
	end

	// Stage 2: signed sine and cosine, operand and coefficient selection.
	logic signed [CW-1:0] sin_c, cos_c, a_x, b_x;
	logic signed [CW-1:0] k0, k1, k2, k3, x0, x1, x2, x3;

	always_comb begin
		sin_c = {2'b00, sin_mag_s1};
		cos_c = {2'b00, cos_mag_s1};
		if (sin_neg_s1) sin_c = -sin_c;
		if (cos_neg_s1) cos_c = -cos_c;
		a_x = {a_s1[15], a_s1};
		b_x = {b_s1[15], b_s1};
	end

	always_comb begin
		k0 = '0; x0 = '0;
		k1 = '0; x1 = '0;
		k2 = '0; x2 = '0;
		k3 = '0; x3 = '0;
		unique case (mode_s1)
			cpt_pkg::MODE_CLARKE: begin
				k0 = cpt_pkg::C_TWO_THIRDS; x0 = a_x;
				k1 = cpt_pkg::C_NEG_THIRD;  x1 = bpc_s1;
				k2 = cpt_pkg::C_SQRT3_3;    x2 = bmc_s1;
			end
			cpt_pkg::MODE_ICLARKE: begin
				k0 = cpt_pkg::C_ONE;        x0 = a_x;
				k2 = cpt_pkg::C_NEG_HALF;   x2 = a_x;
				k3 = cpt_pkg::C_SQRT3_2;    x3 = b_x;
			end
			cpt_pkg::MODE_PARK: begin
				k0 = cos_c;  x0 = a_x;
				k1 = sin_c;  x1 = b_x;
				k2 = cos_c;  x2 = b_x;
				k3 = -sin_c; x3 = a_x;
			end
			cpt_pkg::MODE_IPARK: begin
				k0 = cos_c;  x0 = a_x;
				k1 = -sin_c; x1 = b_x;
				k2 = sin_c;  x2 = a_x;
				k3 = cos_c;  x3 = b_x;
			end
		endcase
	end

	cpt_pkg::mode_t       mode_s2;
	logic signed [PW-1:0] p0_s2, p1_s2, p2_s2, p3_s2;

	// Four products, registered.
	always_ff @(posedge clk) begin
		if (en2) begin
			mode_s2 <= mode_s1;
			p0_s2   <= k0 * x0;
			p1_s2   <= k1 * x1;
			p2_s2   <= k2 * x2;
			p3_s2   <= k3 * x3;
		end
	end

	// Stage 3: product sums, rounding and clipping.
	logic signed [SW-1:0] sum_a, sum_b, sum_c;
	cpt_pkg::sat_res_t    res_a, res_b, res_c;

	assign sum_a = {p0_s2[PW-1], p0_s2} + {p1_s2[PW-1], p1_s2};
	assign sum_b = {p2_s2[PW-1], p2_s2} + {p3_s2[PW-1], p3_s2};
	assign sum_c = {p2_s2[PW-1], p2_s2} - {p3_s2[PW-1], p3_s2};
	assign res_a = cpt_pkg::round_sat(sum_a);
	assign res_b = cpt_pkg::round_sat(sum_b);
	assign res_c = cpt_pkg::round_sat(sum_c);

	cpt_pkg::mode_t     mode_s3;
	logic signed [15:0] oa_s3, ob_s3, oc_s3;
	logic               sat_s3;

	// Output register; out_c only carries a value in inverse Clarke.
	always_ff @(posedge clk) begin
		if (en3) begin
			mode_s3 <= mode_s2;
			oa_s3   <= res_a.val;
			ob_s3   <= res_b.val;
			if (mode_s2 == cpt_pkg::MODE_ICLARKE) begin
				oc_s3  <= res_c.val;
				sat_s3 <= res_a.sat | res_b.sat | res_c.sat;
			end else begin
				oc_s3  <= '0;
				sat_s3 <= res_a.sat | res_b.sat;
			end
		end
	end

	assign m_axis_tvalid = v_s3;
	assign m_axis_tdata  = {oc_s3, ob_s3, oa_s3};
	assign m_axis_tuser  = sat_s3;

	// A saturated result must show at least one output at a range limit.
	a_sat_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[0]) |->
			(oa_s3 == 16'sh7FFF || oa_s3 == 16'sh8000 ||
			 ob_s3 == 16'sh7FFF || ob_s3 == 16'sh8000 ||
			 oc_s3 == 16'sh7FFF || oc_s3 == 16'sh8000))
		else $error("saturated flag without a clipped output");

	// Phase c is only produced by the inverse Clarke transform.
	a_outc_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && mode_s3 != cpt_pkg::MODE_ICLARKE) |-> (oc_s3 == 16'sd0))
		else $error("out_c nonzero outside inverse Clarke");

	// A stalled output stage keeps the stages behind it from advancing into it.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && v_s3 && !m_axis_tready) |=> (v_s3 && $stable(oa_s3) && $stable(ob_s3)))
		else $error("output stage overwritten while stalled");

endmodule

// ===== verif/clarke_park_transform_checker.sv =====
// Scoreboard for the Clarke/Park transform: watches both stream channels,
// predicts each result from the accepted sample set and compares it in order.
// Depends on cpt_pkg for the mode type and the angle resolution.
`timescale 1ns / 1ps

module clarke_park_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [63:0] s_tdata,    // in_a[15:0], in_b[31:16], in_c[47:32], angle[59:48]
	input  logic [1:0]  s_tuser,    // mode[1:0]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [47:0] m_tdata,    // out_a[15:0], out_b[31:16], out_c[47:32]
	input  logic [0:0]  m_tuser,    // saturated[0]
	output int          fail_count,
	output int          pending
);

	localparam int  FULL_TURN    = 1 << cpt_pkg::ANGLE_BITS;
	localparam int  QUARTER_TURN = FULL_TURN >> 2;
	localparam real HALF_PI      = 1.57079632679489661923;

	// Rounded Q1.15 coefficients of the four transforms.
	localparam longint K_TWO_THIRDS = 21845;
	localparam longint K_THIRD      = 10923;
	localparam longint K_SQRT3_3    = 18919;
	localparam longint K_ONE        = 32768;
	localparam longint K_HALF       = 16384;
	localparam longint K_SQRT3_2    = 28378;

	typedef struct packed {
		logic                clip;
		logic signed [15:0]  val;
	} q15_clip_t;

	typedef struct {
		cpt_pkg::mode_t      mode;
		logic signed [15:0]  out_a;
		logic signed [15:0]  out_b;
		logic signed [15:0]  out_c;
		logic                sat;
	} q15_result_t;

	int unsigned  quarter_sine [QUARTER_TURN+1];
	q15_result_t  expected_results [$];
	int           errors = 0;

	// Quarter-wave table of round(32767 * sin) over 0 .. pi/2.
	initial begin
		for (int r = 0; r <= QUARTER_TURN; r++)
			quarter_sine[r] = $rtoi(32767.0 * $sin(HALF_PI * r / QUARTER_TURN) + 0.5);
	end

	// Signed sine of a binary angle, unfolded from the quarter table.
	function automatic longint sine_at(input int unsigned k);
		int unsigned quad;
		int unsigned r;
		k    = k & (FULL_TURN - 1);
		quad = k >> (cpt_pkg::ANGLE_BITS - 2);
		r    = k & (QUARTER_TURN - 1);
		case (quad)
			0:       return longint'(quarter_sine[r]);
			1:       return longint'(quarter_sine[QUARTER_TURN - r]);
			2:       return -longint'(quarter_sine[r]);
			default: return -longint'(quarter_sine[QUARTER_TURN - r]);
		endcase
	endfunction

	// Round a Q2.30 sum half up to Q1.15 and clip it to the Q1.15 range.
	function automatic q15_clip_t round_q15(input longint acc);
		q15_clip_t res;
		longint    q;
		q = (acc + 16384) >>> 15;
		res.clip = 1'b1;
		if (q > 32767)
			res.val = 16'sh7FFF;
		else if (q < -32768)
			res.val = 16'sh8000;
		else begin
			res.clip = 1'b0;
			res.val  = q[15:0];
		end
		return res;
	endfunction

	// Expected output vector for one accepted sample set.
	function automatic q15_result_t predict_transform(input cpt_pkg::mode_t m,
			input logic signed [15:0] a, input logic signed [15:0] b,
			input logic signed [15:0] c, input logic [11:0] ang);
		q15_result_t r;
		q15_clip_t   x, y, z;
		longint      sa, sb, sc, sn, cs;
		sa = a;
		sb = b;
		sc = c;
		sn = sine_at(ang);
		cs = sine_at(ang + QUARTER_TURN);
		z  = '0;
		case (m)
			cpt_pkg::MODE_CLARKE: begin
				x = round_q15(K_TWO_THIRDS * sa - K_THIRD * sb - K_THIRD * sc);
				y = round_q15(K_SQRT3_3 * sb - K_SQRT3_3 * sc);
			end
			cpt_pkg::MODE_ICLARKE: begin
				x = round_q15(K_ONE * sa);
				y = round_q15(-K_HALF * sa + K_SQRT3_2 * sb);
				z = round_q15(-K_HALF * sa - K_SQRT3_2 * sb);
			end
			cpt_pkg::MODE_PARK: begin
				x = round_q15(cs * sa + sn * sb);
				y = round_q15(cs * sb - sn * sa);
			end
			default: begin
				x = round_q15(cs * sa - sn * sb);
				y = round_q15(sn * sa + cs * sb);
			end
		endcase
		r.mode  = m;
		r.out_a = x.val;
		r.out_b = y.val;
		r.out_c = z.val;
		r.sat   = x.clip | y.clip | z.clip;
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		$display("ERROR %0t: %s", $time, what);
		errors++;
	endtask

	// Queue a prediction per input transaction, check each output transaction.
	always @(posedge clk) begin
		q15_result_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				expected_results.push_back(predict_transform(cpt_pkg::mode_t'(s_tuser),
					s_tdata[15:0], s_tdata[31:16], s_tdata[47:32], s_tdata[59:48]));
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0)
					report_mismatch("output transaction with no input pending");
				else begin
					want = expected_results.pop_front();
					if ($signed(m_tdata[15:0]) !== want.out_a)
						report_mismatch($sformatf("%s out_a got %0d want %0d",
							want.mode.name(), $signed(m_tdata[15:0]), want.out_a));
					if ($signed(m_tdata[31:16]) !== want.out_b)
						report_mismatch($sformatf("%s out_b got %0d want %0d",
							want.mode.name(), $signed(m_tdata[31:16]), want.out_b));
					if ($signed(m_tdata[47:32]) !== want.out_c)
						report_mismatch($sformatf("%s out_c got %0d want %0d",
							want.mode.name(), $signed(m_tdata[47:32]), want.out_c));
					if (m_tuser[0] !== want.sat)
						report_mismatch($sformatf("%s saturated got %b want %b",
							want.mode.name(), m_tuser[0], want.sat));
				end
			end
		end
		pending    <= expected_results.size();
		fail_count <= errors;
	end

endmodule

// ===== verif/clarke_park_transform_tb.sv =====
// Top of the Clarke/Park transform testbench: clock, reset, stimulus and verdict.
// Depends on cpt_pkg, clarke_park_transform and clarke_park_checker.
`timescale 1ns / 1ps

module clarke_park_transform_tb;

	localparam int IDLE_LIMIT = 2000;

	logic        clk;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata  = '0;   // in_a[15:0], in_b[31:16], in_c[47:32], angle[59:48]
	logic [1:0]  s_axis_tuser  = cpt_pkg::MODE_CLARKE;   // mode[1:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;         // out_a[15:0], out_b[31:16], out_c[47:32]
	logic [0:0]  m_axis_tuser;         // saturated[0]

	int fail_count;
	int pending;
	int src_idle_pct  = 0;
	int sink_stall_pct = 0;

	clarke_park_transform i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	clarke_park_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_axis_tvalid),
		.s_tready   (s_axis_tready),
		.s_tdata    (s_axis_tdata),
		.s_tuser    (s_axis_tuser),
		.m_tvalid   (m_axis_tvalid),
		.m_tready   (m_axis_tready),
		.m_tdata    (m_axis_tdata),
		.m_tuser    (m_axis_tuser),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Output side backpressure at the rate of the current phase.
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
	end

	// Ends the run when neither channel has moved a transaction for too long.
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("FAIL clarke_park_transform");
		$finish;
	end

	// Offer one sample set, idling first at the phase rate, and wait for acceptance.
	task automatic push_sample(input cpt_pkg::mode_t m, input logic [15:0] a,
			input logic [15:0] b, input logic [15:0] c, input logic [11:0] ang);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {4'b0, ang, c, b, a};
		s_axis_tuser  <= m;
		do
			@(posedge clk);
		while (!s_axis_tready);
	endtask

	// Hold the input side until every queued result has come out.
	task automatic drain_pause();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// Full-scale or near full-scale value of either sign, to push the sums toward the clip points.
	function automatic logic [15:0] rail_value();
		case ($urandom_range(5))
			0:       return 16'h7FFF;
			1:       return 16'h8000;
			2:       return 16'h8001;
			3:       return 16'h7FFE;
			4:       return 16'($urandom_range(32767, 24000));
			default: return 16'(-int'($urandom_range(32767, 24000)));
		endcase
	endfunction

	// One random sample set: noise, plausible motor signals, extremes or small values.
	task automatic push_random();
		int             kind;
		int             amp;
		int             pa, pb;
		logic [11:0]    ang;
		cpt_pkg::mode_t m;
		kind = $urandom_range(99);
		m    = cpt_pkg::mode_t'($urandom_range(3));
		ang  = 12'($urandom);
		if (kind < 35) begin
			push_sample(m, 16'($urandom), 16'($urandom), 16'($urandom), ang);
		end else if (kind < 60) begin
			// Balanced three-phase set, so that a + b + c is zero.
			amp = $urandom_range(16383);
			pa  = int'($urandom_range(2 * amp)) - amp;
			pb  = int'($urandom_range(2 * amp)) - amp;
			push_sample(m, 16'(pa), 16'(pb), 16'(-(pa + pb)), ang);
		end else if (kind < 80) begin
			push_sample(m, rail_value(), rail_value(), rail_value(), ang);
		end else begin
			// Small in_a and in_b values with the angle close to a quadrant boundary.
			ang = 12'($urandom_range(3) * 1024 + $urandom_range(4) - 2);
			push_sample(m, 16'(int'($urandom_range(511)) - 256),
				16'(int'($urandom_range(511)) - 256), 16'($urandom), ang);
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed sample sets: zero, full scale, clipping in every mode, ignored
		// fields, and angles on the quadrant boundaries.
		push_sample(cpt_pkg::MODE_CLARKE,  16'h0000, 16'h0000, 16'h0000, 12'h000);
		push_sample(cpt_pkg::MODE_CLARKE,  16'h7FFF, 16'h8000, 16'h8000, 12'hFFF);
		push_sample(cpt_pkg::MODE_CLARKE,  16'h8000, 16'h7FFF, 16'h7FFF, 12'h000);
		push_sample(cpt_pkg::MODE_CLARKE,  16'h0000, 16'h7FFF, 16'h8000, 12'h123);
		push_sample(cpt_pkg::MODE_CLARKE,  16'h4000, 16'hE000, 16'hE000, 12'h800);
		push_sample(cpt_pkg::MODE_ICLARKE, 16'h8000, 16'h7FFF, 16'h7FFF, 12'hFFF);
		push_sample(cpt_pkg::MODE_ICLARKE, 16'h7FFF, 16'h8000, 16'h8000, 12'h000);
		push_sample(cpt_pkg::MODE_ICLARKE, 16'h8000, 16'h8000, 16'h1234, 12'h555);
		push_sample(cpt_pkg::MODE_ICLARKE, 16'h4000, 16'h0000, 16'h7FFF, 12'h000);
		push_sample(cpt_pkg::MODE_PARK,    16'h7FFF, 16'h7FFF, 16'hFFFF, 12'h200);
		push_sample(cpt_pkg::MODE_PARK,    16'h8000, 16'h8000, 16'h0000, 12'h200);
		push_sample(cpt_pkg::MODE_PARK,    16'h7FFF, 16'h0000, 16'h0000, 12'h000);
		push_sample(cpt_pkg::MODE_PARK,    16'h7FFF, 16'h1000, 16'h0000, 12'h400);
		push_sample(cpt_pkg::MODE_PARK,    16'h8000, 16'h7FFF, 16'h0000, 12'h800);
		push_sample(cpt_pkg::MODE_PARK,    16'h2000, 16'hC000, 16'h0000, 12'hC00);
		push_sample(cpt_pkg::MODE_IPARK,   16'h7FFF, 16'h8000, 16'hAAAA, 12'h200);
		push_sample(cpt_pkg::MODE_IPARK,   16'h8000, 16'h8000, 16'h5555, 12'h600);
		push_sample(cpt_pkg::MODE_IPARK,   16'h7FFF, 16'h7FFF, 16'h0000, 12'hFFF);
		push_sample(cpt_pkg::MODE_IPARK,   16'h1000, 16'h2000, 16'h0000, 12'h3FF);
		push_sample(cpt_pkg::MODE_IPARK,   16'h8000, 16'h0000, 16'h0000, 12'hA00);
		drain_pause();

		// Random phases: free flow, slow source, slow sink, both slow.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
				1: begin src_idle_pct = 73; sink_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  sink_stall_pct = 73; end
				default: begin src_idle_pct = 32; sink_stall_pct = 32; end
			endcase
			for (int n = 0; n < 110; n++)
				push_random();
			drain_pause();
		end

		src_idle_pct   = 0;
		sink_stall_pct = 0;
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("PASS clarke_park_transform");
		else
			$display("FAIL clarke_park_transform");
		$finish;
	end

endmodule
